@@ sv/zac_pkg.sv @@
// Shared constants and types for the zone average color block.
package zac_pkg;

    localparam int DEFAULT_NUM_ZONES = 16;

    // Field and register widths.
    localparam int PIXEL_W  = 24;
    localparam int CHAN_W   = 8;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 26;
    localparam int CW_W     = 14;
    localparam int RW_W     = 13;
    localparam int RH_W     = 13;
    localparam int COL_W    = 13;
    localparam int ROW_W    = 12;
    localparam int ZONE_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Hard limits on the line length and the strip height.
    localparam logic [COL_W-1:0] MAX_COLUMN = 13'd8191;
    localparam logic [ROW_W-1:0] MAX_ROW    = 12'd4095;
    localparam logic [CW_W-1:0]  MAX_WIDTH  = 14'd8192;
    localparam logic [RH_W-1:0]  MAX_HEIGHT = 13'd4096;

    // Register values after reset.
    localparam logic [CW_W-1:0]      RST_CAPTURE_WIDTH  = 14'd1920;
    localparam logic [RW_W-1:0]      RST_REGION_WIDTH   = 13'd120;
    localparam logic [RH_W-1:0]      RST_REGION_HEIGHT  = 13'd480;
    localparam logic [PIXEL_W-1:0]   RST_RED_CHAN_MASK  = 24'hFF0000;
    localparam logic [PIXEL_W-1:0]   RST_GRN_CHAN_MASK  = 24'h00FF00;
    localparam logic [PIXEL_W-1:0]   RST_BLU_CHAN_MASK  = 24'h0000FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPTURE_WIDTH = 3'd0,
        CFG_REGION_WIDTH  = 3'd1,
        CFG_REGION_HEIGHT = 3'd2,
        CFG_RED_CHAN_MASK = 3'd3,
        CFG_GRN_CHAN_MASK = 3'd4,
        CFG_BLU_CHAN_MASK = 3'd5
    } t_cfg_index;

    // Handshake between the sequencer and one channel divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage

@@ sv/zac_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module zac_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/zac_div.sv @@
// Restoring divider that produces an 8-bit quotient, one bit per cycle.
module zac_div
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  zac_pkg::t_div_ctl           i_ctl,
    input  logic [zac_pkg::SUM_W-1:0]   i_dividend,
    input  logic [zac_pkg::COUNT_W-1:0] i_divisor,
    output zac_pkg::t_div_sts           o_sts,
    output logic [zac_pkg::CHAN_W-1:0]  o_quotient
);
    import zac_pkg::*;

    localparam int STEP_W = $clog2(CHAN_W);
    localparam int DSH_W  = COUNT_W + CHAN_W - 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [CHAN_W-1:0] r_q;
    logic              r_zero;

    logic             fits;
    logic [DSH_W-1:0] diff;

    // The quotient never exceeds 255 because a zone sum holds at most
    // 255 per counted pixel, so eight bits of long division suffice.
    assign fits = {{(DSH_W-SUM_W){1'b0}}, r_rem} >= r_dsh;
    assign diff = {{(DSH_W-SUM_W){1'b0}}, r_rem} - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CHAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_dividend;
            r_dsh  <= {i_divisor, {(CHAN_W-1){1'b0}}};
            r_q    <= '0;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= diff[SUM_W-1:0];
            end
            r_q   <= {r_q[CHAN_W-2:0], fits};
            r_dsh <= {1'b0, r_dsh[DSH_W-1:1]};
        end
    end

    assign o_sts.done = r_done;
    assign o_quotient = r_zero ? '0 : r_q;

endmodule

@@ sv/zone_average_color_top.sv @@
// Top level of the zone average color block: accumulation, sequencing and output.
//
// Pixels of a strip are accepted one per clock: each transfer reads its zone's
// three running sums from the sum RAM, and the sum is added and written back on
// the next cycle, with a bypass when consecutive pixels hit the same zone. The
// start-of-frame pixel clears the sums through per-zone valid bits, so no
// clearing pass is needed. After the last pixel of the strip the input stalls
// while the results are produced: the last write drains, then for each zone
// come the RAM read with the divisor product, the load, eight quotient steps
// of the three channel dividers, a step to collect the quotients and the
// output transfer, which the sink may hold off. Pixels that arrive after the
// results are sent and before the next start-of-frame mark are taken and dropped.
module zone_average_color_top #(
    parameter int NUM_ZONES = zac_pkg::DEFAULT_NUM_ZONES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration writes.
    input  logic                          i_cfg_we,
    input  logic [zac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [zac_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // Pixel stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // [23:0] pixel_value
    input  logic                          s_axis_tuser,  // [0] start_of_frame
    // Zone result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [5:0] zone_index, [13:6] avg_red, [21:14] avg_green, [29:22] avg_blue
    output logic [31:0]                   m_axis_tdata,
    output logic                          m_axis_tlast   // last_zone
);
    import zac_pkg::*;

    localparam int ZAW    = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int ZCW    = $clog2(NUM_ZONES + 1);
    localparam int RAM_W  = 3 * SUM_W;
    localparam int START_W = COL_W + 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_SEND
    } t_state;

    // Configuration registers.
    logic [CW_W-1:0]    r_capture_width;
    logic [RW_W-1:0]    r_region_width;
    logic [RH_W-1:0]    r_region_height;
    logic [PIXEL_W-1:0] r_red_chan_mask;
    logic [PIXEL_W-1:0] r_grn_chan_mask;
    logic [PIXEL_W-1:0] r_blu_chan_mask;

    // Control state.
    t_state             r_state;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ZCW-1:0]     r_zone;
    logic [RW_W-1:0]    r_zcol;
    logic [NUM_ZONES-1:0] r_valid;
    logic               r_s1_valid;
    logic [ZAW-1:0]     r_oz;
    logic [START_W-1:0] r_start;
    logic               r_out_valid;

    // Payload registers.
    logic [ZAW-1:0]     r_s1_zone;
    logic [CHAN_W-1:0]  r_s1_red;
    logic [CHAN_W-1:0]  r_s1_grn;
    logic [CHAN_W-1:0]  r_s1_blu;
    logic               r_s1_base_ok;
    logic               r_byp;
    logic [RAM_W-1:0]   r_byp_data;
    logic [COUNT_W-1:0] r_n;
    logic [ZONE_W-1:0]  r_out_zone;
    logic [CHAN_W-1:0]  r_out_red;
    logic [CHAN_W-1:0]  r_out_grn;
    logic [CHAN_W-1:0]  r_out_blu;
    logic               r_out_last;

    logic               in_xfer;
    logic               sof;
    logic               pix_active;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [ZCW-1:0]     zone;
    logic [RW_W-1:0]    zcol;
    logic [ZAW-1:0]     za;
    logic               counted;
    logic               line_end;
    logic               row_end;
    logic               zone_end;
    logic               same_zone;
    logic [PIXEL_W-1:0] px_red;
    logic [PIXEL_W-1:0] px_grn;
    logic [PIXEL_W-1:0] px_blu;

    logic [RAM_W-1:0]   rdata;
    logic [RAM_W-1:0]   base;
    logic [RAM_W-1:0]   wdata;
    logic [ZAW-1:0]     raddr;

    logic [CW_W-1:0]    eff_w;
    logic [RH_W-1:0]    eff_h;
    logic [CW_W-1:0]    span;
    logic [CW_W-1:0]    cols;
    logic [COUNT_W-1:0] n_n;

    t_div_ctl           div_ctl;
    t_div_sts           sts_red;
    t_div_sts           sts_grn;
    t_div_sts           sts_blu;
    logic [CHAN_W-1:0]  q_red;
    logic [CHAN_W-1:0]  q_grn;
    logic [CHAN_W-1:0]  q_blu;
    logic [RAM_W-1:0]   dividend;
    logic               last_oz;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_width <= RST_CAPTURE_WIDTH;
            r_region_width  <= RST_REGION_WIDTH;
            r_region_height <= RST_REGION_HEIGHT;
            r_red_chan_mask <= RST_RED_CHAN_MASK;
            r_grn_chan_mask <= RST_GRN_CHAN_MASK;
            r_blu_chan_mask <= RST_BLU_CHAN_MASK;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CAPTURE_WIDTH: r_capture_width <= i_cfg_data[CW_W-1:0];
                CFG_REGION_WIDTH:  r_region_width  <= i_cfg_data[RW_W-1:0];
                CFG_REGION_HEIGHT: r_region_height <= i_cfg_data[RH_W-1:0];
                CFG_RED_CHAN_MASK: r_red_chan_mask <= i_cfg_data[PIXEL_W-1:0];
                CFG_GRN_CHAN_MASK: r_grn_chan_mask <= i_cfg_data[PIXEL_W-1:0];
                CFG_BLU_CHAN_MASK: r_blu_chan_mask <= i_cfg_data[PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- pixel decode
    assign s_axis_tready = (r_state == ST_IDLE) || (r_state == ST_RUN);
    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign sof        = s_axis_tuser;
    assign pix_active = in_xfer && (sof || (r_state == ST_RUN));

    // A start-of-frame pixel is counted as if every counter were zero.
    assign col  = sof ? '0 : r_col;
    assign row  = sof ? '0 : r_row;
    assign zone = sof ? '0 : r_zone;
    assign zcol = sof ? '0 : r_zcol;
    assign za   = zone[ZAW-1:0];

    // Every column stays inside the effective line width, so only a nonzero region
    // width and the zone number decide whether a pixel is counted.
    assign counted  = (r_region_width != '0) && (zone < ZCW'(NUM_ZONES));
    assign line_end = ({1'b0, col} + CW_W'(1) >= r_capture_width) || (col == MAX_COLUMN);
    assign row_end  = ({1'b0, row} + RH_W'(1) >= r_region_height) || (row == MAX_ROW);
    assign zone_end = ({1'b0, zcol} + 14'd1) == {1'b0, r_region_width};
    assign same_zone = r_s1_valid && (r_s1_zone == za);

    assign px_red = s_axis_tdata & r_red_chan_mask;
    assign px_grn = s_axis_tdata & r_grn_chan_mask;
    assign px_blu = s_axis_tdata & r_blu_chan_mask;

    // ---------------------------------------------------------- sum RAM path
    assign raddr = (r_state == ST_READ) ? r_oz : za;

    assign base = !r_s1_base_ok ? '0 : (r_byp ? r_byp_data : rdata);
    assign wdata[SUM_W-1:0]         = base[SUM_W-1:0] + SUM_W'(r_s1_red);
    assign wdata[2*SUM_W-1:SUM_W]   = base[2*SUM_W-1:SUM_W] + SUM_W'(r_s1_grn);
    assign wdata[3*SUM_W-1:2*SUM_W] = base[3*SUM_W-1:2*SUM_W] + SUM_W'(r_s1_blu);

    zac_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_ZONES)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_zone),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        r_s1_zone    <= za;
        r_s1_red     <= px_red[23:16];
        r_s1_grn     <= px_grn[15:8];
        r_s1_blu     <= px_blu[7:0];
        r_s1_base_ok <= !sof && (r_valid[za] || same_zone);
        r_byp        <= same_zone;
        r_byp_data   <= wdata;
    end

    // ------------------------------------------------------ divisor per zone
    assign eff_w = (r_capture_width == '0) ? CW_W'(1) :
                   (r_capture_width > MAX_WIDTH) ? MAX_WIDTH : r_capture_width;
    assign eff_h = (r_region_height == '0) ? RH_W'(1) :
                   (r_region_height > MAX_HEIGHT) ? MAX_HEIGHT : r_region_height;
    assign span  = eff_w - r_start[CW_W-1:0];
    assign cols  = ((r_region_width == '0) || (r_start >= START_W'(eff_w))) ? '0 :
                   (span > {1'b0, r_region_width}) ? {1'b0, r_region_width} : span;
    assign n_n   = COUNT_W'(cols[RW_W-1:0]) * COUNT_W'(eff_h);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_n <= n_n;
        end
    end

    // ------------------------------------------------------------- dividers
    assign div_ctl.start = (r_state == ST_LOAD);
    assign dividend      = r_valid[r_oz] ? rdata : '0;

    zac_div u_div_red (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (dividend[SUM_W-1:0]),
        .i_divisor  (r_n),
        .o_sts      (sts_red),
        .o_quotient (q_red)
    );

    zac_div u_div_grn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (dividend[2*SUM_W-1:SUM_W]),
        .i_divisor  (r_n),
        .o_sts      (sts_grn),
        .o_quotient (q_grn)
    );

    zac_div u_div_blu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (dividend[3*SUM_W-1:2*SUM_W]),
        .i_divisor  (r_n),
        .o_sts      (sts_blu),
        .o_quotient (q_blu)
    );

    assign last_oz = (r_oz == ZAW'(NUM_ZONES - 1));

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_zone      <= '0;
            r_zcol      <= '0;
            r_valid     <= '0;
            r_s1_valid  <= 1'b0;
            r_oz        <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= pix_active && counted;

            // Start of frame discards every sum; a write still in flight
            // from the old frame lands in the RAM but is never read.
            if (in_xfer && sof) begin
                r_valid <= '0;
            end else if (r_s1_valid) begin
                r_valid[r_s1_zone] <= 1'b1;
            end

            unique case (r_state) inside
                ST_IDLE, ST_RUN: begin
                    if (pix_active) begin
                        if (!line_end) begin
                            r_col <= col + 1'b1;
                            r_row <= row;
                            if (zone_end) begin
                                r_zcol <= '0;
                                r_zone <= (zone == ZCW'(NUM_ZONES)) ? zone : zone + 1'b1;
                            end else begin
                                r_zone <= zone;
                                r_zcol <= zcol + 1'b1;
                            end
                            r_state <= ST_RUN;
                        end else begin
                            r_col  <= '0;
                            r_zone <= '0;
                            r_zcol <= '0;
                            if (!row_end) begin
                                r_row   <= row + 1'b1;
                                r_state <= ST_RUN;
                            end else begin
                                r_row   <= '0;
                                r_state <= ST_DRAIN;
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    r_oz    <= '0;
                    r_start <= '0;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (sts_red.done && sts_grn.done && sts_blu.done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        if (last_oz) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_oz    <= r_oz + 1'b1;
                            r_start <= r_start + START_W'(r_region_width);
                            r_state <= ST_READ;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV) begin
            r_out_zone <= ZONE_W'(r_oz);
            r_out_red  <= q_red;
            r_out_grn  <= q_grn;
            r_out_blu  <= q_blu;
            r_out_last <= last_oz;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_blu, r_out_grn, r_out_red, r_out_zone};
    assign m_axis_tlast  = r_out_last;

endmodule

@@ tb/zone_average_color_top_tb.sv @@
// Self-checking testbench for zone_average_color_top: predicts each zone average and checks it.
module zone_average_color_top_tb;
    import zac_pkg::*;

    localparam int ZONES         = DEFAULT_NUM_ZONES;
    localparam int IDLE_PCT      = 37;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_PIXELS = 60;

    localparam logic [PIXEL_W-1:0] EXTREME_PIXELS [8] = '{
        24'h000000, 24'hFFFFFF, 24'h800000, 24'h008000,
        24'h000080, 24'h7F7F7F, 24'h010203, 24'hFEFDFC
    };

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_zone_avg;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // [23:0] pixel_value
    logic                 s_axis_tuser = 1'b0; // [0] start_of_frame
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [5:0] zone_index, [13:6] avg_red, [21:14] avg_green, [29:22] avg_blue
    logic [31:0]          m_axis_tdata;
    logic                 m_axis_tlast;        // last_zone

    // Predictor copy of the registers and the strip state.
    logic [CW_W-1:0]    cap_width     = RST_CAPTURE_WIDTH;
    logic [RW_W-1:0]    reg_width     = RST_REGION_WIDTH;
    logic [RH_W-1:0]    reg_height    = RST_REGION_HEIGHT;
    logic [PIXEL_W-1:0] red_chan_mask = RST_RED_CHAN_MASK;
    logic [PIXEL_W-1:0] grn_chan_mask = RST_GRN_CHAN_MASK;
    logic [PIXEL_W-1:0] blu_chan_mask = RST_BLU_CHAN_MASK;
    int                 col_pos    = 0;
    int                 row_pos    = 0;
    bit                 strip_idle = 1'b1;
    logic [SUM_W-1:0]   red_acc   [ZONES] = '{default: '0};
    logic [SUM_W-1:0]   green_acc [ZONES] = '{default: '0};
    logic [SUM_W-1:0]   blue_acc  [ZONES] = '{default: '0};

    t_zone_avg expected_avgs[$];
    int        errors  = 0;
    bit        no_idle = 1'b0;

    zone_average_color_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int line_pixels();
        if (cap_width == 0) return 1;
        return (int'(cap_width) > int'(MAX_WIDTH)) ? int'(MAX_WIDTH) : int'(cap_width);
    endfunction

    function automatic int strip_rows();
        if (reg_height == 0) return 1;
        return (int'(reg_height) > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : int'(reg_height);
    endfunction

    function automatic int strip_len();
        return line_pixels() * strip_rows();
    endfunction

    // Adds one accepted pixel to its zone; at the end of the strip the
    // averages of all zones are queued.
    function automatic void accumulate_pixel(input logic [PIXEL_W-1:0] px, input logic sof);
        logic [PIXEL_W-1:0] chan;
        int                 z;
        int                 w;
        int                 first;
        int                 cols;
        int                 n;
        t_zone_avg          avg;
        if (sof) begin
            col_pos = 0;
            row_pos = 0;
            red_acc = '{default: '0};
            green_acc = '{default: '0};
            blue_acc = '{default: '0};
            strip_idle = 1'b0;
        end else if (strip_idle) begin
            return;
        end
        w = line_pixels();
        if (reg_width != 0 && col_pos < w) begin
            z = col_pos / int'(reg_width);
            if (z < ZONES) begin
                chan = (px & red_chan_mask) >> 16;
                red_acc[z] += SUM_W'(chan[CHAN_W-1:0]);
                chan = (px & grn_chan_mask) >> 8;
                green_acc[z] += SUM_W'(chan[CHAN_W-1:0]);
                chan = px & blu_chan_mask;
                blue_acc[z] += SUM_W'(chan[CHAN_W-1:0]);
            end
        end
        if (col_pos + 1 < int'(cap_width) && col_pos < int'(MAX_COLUMN)) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < int'(reg_height) && row_pos < int'(MAX_ROW)) begin
            row_pos++;
            return;
        end
        row_pos = 0;
        strip_idle = 1'b1;
        for (z = 0; z < ZONES; z++) begin
            first = z * int'(reg_width);
            if (reg_width == 0 || first >= w) begin
                n = 0;
            end else begin
                cols = w - first;
                if (cols > int'(reg_width)) cols = int'(reg_width);
                n = cols * strip_rows();
            end
            avg.zone  = ZONE_W'(z);
            avg.red   = (n == 0) ? '0 : CHAN_W'(red_acc[z] / n);
            avg.green = (n == 0) ? '0 : CHAN_W'(green_acc[z] / n);
            avg.blue  = (n == 0) ? '0 : CHAN_W'(blue_acc[z] / n);
            avg.last  = (z == ZONES - 1);
            expected_avgs.push_back(avg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Compares each result transfer with the oldest queued average.
    always @(posedge i_clk) begin
        t_zone_avg want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_avgs.size() == 0) begin
                $error("zone result with no average pending: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_avgs.pop_front();
                check_field("zone_index", 8'(want.zone), 8'(m_axis_tdata[5:0]));
                check_field("avg_red", want.red, m_axis_tdata[13:6]);
                check_field("avg_green", want.green, m_axis_tdata[21:14]);
                check_field("avg_blue", want.blue, m_axis_tdata[29:22]);
                check_field("last_zone", 8'(want.last), 8'(m_axis_tlast));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("zone_average_color_top test failed");
        $finish;
    end

    // All driving tasks are entered and left at a falling edge.
    task automatic cfg_write(input t_cfg_index idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_CAPTURE_WIDTH: cap_width = val[CW_W-1:0];
            CFG_REGION_WIDTH:  reg_width = val[RW_W-1:0];
            CFG_REGION_HEIGHT: reg_height = val[RH_W-1:0];
            CFG_RED_CHAN_MASK: red_chan_mask = val;
            CFG_GRN_CHAN_MASK: grn_chan_mask = val;
            CFG_BLU_CHAN_MASK: blu_chan_mask = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int cw, input int rw, input int rh);
        cfg_write(CFG_CAPTURE_WIDTH, CFG_DAT_W'(cw));
        cfg_write(CFG_REGION_WIDTH, CFG_DAT_W'(rw));
        cfg_write(CFG_REGION_HEIGHT, CFG_DAT_W'(rh));
    endtask

    task automatic set_masks(input logic [PIXEL_W-1:0] r, input logic [PIXEL_W-1:0] g,
                             input logic [PIXEL_W-1:0] b);
        cfg_write(CFG_RED_CHAN_MASK, r);
        cfg_write(CFG_GRN_CHAN_MASK, g);
        cfg_write(CFG_BLU_CHAN_MASK, b);
    endtask

    // Waits for every queued average, then lets the block finish any pixel
    // still in flight before registers change.
    task automatic wait_idle();
        while (expected_avgs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic sof);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = px;
        s_axis_tuser = sof;
        do @(posedge i_clk); while (!s_axis_tready);
        accumulate_pixel(px, sof);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_strip(input int count);
        for (int i = 0; i < count; i++) send_pixel(PIXEL_W'($urandom()), i == 0);
    endtask

    task automatic test_idle_pixels_and_extremes();
        int len;
        // Masks keep their reset values here.
        set_geometry(5, 2, 2);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h123456, 1'b0);
        len = strip_len();
        for (int i = 0; i < len; i++) begin
            send_pixel(i < 8 ? EXTREME_PIXELS[i] : PIXEL_W'($urandom()), i == 0);
        end
    endtask

    task automatic test_restart_mid_strip();
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_strip(strip_len());
        send_pixel(24'hABCDEF, 1'b0);
    endtask

    task automatic test_degenerate_geometry();
        wait_idle();
        set_geometry(0, 1, 0);
        send_strip(strip_len());
        wait_idle();
        set_geometry(3, 0, 1);
        send_strip(strip_len());
        wait_idle();
        set_geometry(3, 8191, 2);
        send_strip(strip_len());
    endtask

    task automatic test_channel_masks();
        wait_idle();
        set_geometry(4, 2, 2);
        set_masks(24'h000000, 24'hFFFFFF, PIXEL_W'($urandom()));
        send_strip(strip_len());
        wait_idle();
        set_masks(PIXEL_W'($urandom()), PIXEL_W'($urandom()), 24'h000000);
        send_strip(strip_len());
        wait_idle();
        set_masks(RST_RED_CHAN_MASK, RST_GRN_CHAN_MASK, RST_BLU_CHAN_MASK);
    endtask

    task automatic test_back_to_back();
        wait_idle();
        // Uneven zones with a partial last zone, pushed through back to back
        // on both sides.
        no_idle = 1'b1;
        set_geometry(20, 3, 2);
        send_strip(strip_len());
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_random_strips();
        int sent;
        int r;
        int cw;
        int rw;
        int len;
        int n;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            wait_idle();
            r = $urandom_range(99);
            cw = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, 12) : $urandom_range(13, 20);
            r = $urandom_range(99);
            rw = (r < 10) ? 0 : (r < 15) ? 8191 : $urandom_range(1, 6);
            set_geometry(cw, rw, $urandom_range(0, 2));
            if ($urandom_range(1) == 1) begin
                set_masks(PIXEL_W'($urandom()), PIXEL_W'($urandom()), PIXEL_W'($urandom()));
            end else begin
                set_masks(RST_RED_CHAN_MASK, RST_GRN_CHAN_MASK, RST_BLU_CHAN_MASK);
            end
            len = strip_len();
            repeat ($urandom_range(1, 2)) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    send_strip(len);
                    sent += len;
                end else if (r < 88 && len > 1) begin
                    // Strip cut short by a new start-of-frame mark.
                    n = $urandom_range(1, len - 1);
                    send_strip(n);
                    send_strip(len);
                    sent += n + len;
                end else begin
                    repeat ($urandom_range(1, 4)) send_pixel(PIXEL_W'($urandom()), 1'b0);
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_idle_pixels_and_extremes();
        test_restart_mid_strip();
        test_degenerate_geometry();
        test_channel_masks();
        test_back_to_back();
        test_random_strips();
        wait_idle();
        if (errors == 0 && expected_avgs.size() == 0) begin
            $display("zone_average_color_top test passed");
        end else begin
            $display("zone_average_color_top test failed");
        end
        $finish;
    end

endmodule

@@ zone_average_color_top.f @@
sv/zac_pkg.sv
sv/zac_ram.sv
sv/zac_div.sv
sv/zone_average_color_top.sv
tb/zone_average_color_top_tb.sv
